@@ src/pmtk_pkg.sv @@
`timescale 1ns / 1ps
package pmtk_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int MAX_LEN_DEF    = 4096;
  localparam int SYM_BITS_DEF   = 8;

  localparam int SCORE_W = 13;
  localparam int ROW_W   = 12;
  localparam int AGE_W   = 32;
  localparam int SLOT_W  = 10;
  localparam int SYM_W   = 8;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 56;

  localparam logic OP_ELEM = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [ROW_W-1:0]   second;
    logic [ROW_W-1:0]   first;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UP_RD  = 8'b0000_0010,
    ST_UP_CMP = 8'b0000_0100,
    ST_DN_L   = 8'b0000_1000,
    ST_DN_R   = 8'b0001_0000,
    ST_DN_CMP = 8'b0010_0000,
    ST_POP_A  = 8'b0100_0000,
    ST_POP_B  = 8'b1000_0000
  } state_t;

  // score first, insertion stamp breaks ties
  function automatic logic key_less(entry_t x, entry_t y);
    logic res;
    if (x.score != y.score) res = (x.score < y.score);
    else res = (x.age < y.age);
    return res;
  endfunction

endpackage

@@ src/pmtk_ram.sv @@
`timescale 1ns / 1ps
module pmtk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/pair_match_top_k_selector.sv @@
`timescale 1ns / 1ps
// element items: one per cycle when idle, output not stalled; a scored pair reports at once
// insert: sift-up over the heap ram, per level read parent, then compare/write
// replace and pop: sift-down, per level read left, read right, then compare/write
// pop fetches root, then last entry (ST_POP_A, ST_POP_B); result registered in ST_POP_A
// rst_n synchronous: count, tally, stamp and threshold clear; heap ram is not cleared
module pair_match_top_k_selector
  import pmtk_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int SYM_BITS   = SYM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_DW-1:0]   in_tdata,   // sym_a, sym_b, first_row, second_row
  input  logic               in_tuser,   // opcode
  input  logic               in_tlast,   // last_element
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_DW-1:0]  out_tdata,  // out_score, out_first, out_second, accepted, slot,
                                         // empty_res, zero fill
  output logic               out_tuser,  // is_pop
  input  logic               cfg_wr_en,
  input  logic [SCORE_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int TW = $clog2(MAX_LEN + 1);
  localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << SYM_BITS) - 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SCORE_W-1:0]  thr_r, thr_nxt;
  logic [TW-1:0]       tally_r, tally_nxt;
  logic [AGE_W-1:0]    age_r, age_nxt;
  entry_t              e_r, e_nxt;
  entry_t              lch_r, lch_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic                repl_r, repl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_pop_r, out_pop_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  entry_t              wr_data, rd_data;

  logic                in_fire;
  logic [SYM_W-1:0]    sym_a, sym_b;
  logic [TW-1:0]       tally_inc;
  logic [SCORE_W-1:0]  score;
  logic                acc;
  logic [AW-1:0]       par;
  logic [CW:0]         lidx, ridx;
  logic                lv, rv;
  entry_t              best;
  logic [CW:0]         best_idx;
  logic                moved;

  pmtk_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pop_r;

  assign sym_a = in_tdata[7:0] & SYM_MASK;
  assign sym_b = in_tdata[15:8] & SYM_MASK;
  assign tally_inc = (sym_a == sym_b && sym_a != '0 && tally_r < TW'(MAX_LEN)) ?
                     tally_r + 1'b1 : tally_r;
  assign score = SCORE_W'(tally_inc);
  assign acc = !(score < thr_r) && ((count_r < CW'(HEAP_DEPTH)) || (score > thr_r));

  assign par  = (pos_r - 1'b1) >> 1;
  assign lidx = ((CW+1)'(pos_r) << 1) + 1'b1;
  assign ridx = lidx + 1'b1;
  assign lv   = lidx < (CW+1)'(count_r);
  assign rv   = ridx < (CW+1)'(count_r);

  always_comb begin
    best     = e_r;
    best_idx = (CW+1)'(pos_r);
    moved    = 1'b0;
    if (lv && key_less(lch_r, best)) begin
      best     = lch_r;
      best_idx = lidx;
      moved    = 1'b1;
    end
    if (rv && key_less(rd_data, best)) begin
      best     = rd_data;
      best_idx = ridx;
      moved    = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    thr_nxt       = thr_r;
    tally_nxt     = tally_r;
    age_nxt       = age_r;
    e_nxt         = e_r;
    lch_nxt       = lch_r;
    pos_nxt       = pos_r;
    repl_nxt      = repl_r;
    out_valid_nxt = out_valid_r;
    out_pop_nxt   = out_pop_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = e_r;
    rd_addr       = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_POP) begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_pop_nxt   = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt[48] = 1'b1;
            end else begin
              state_nxt = ST_POP_A;
            end
          end else if (in_tlast) begin
            tally_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_pop_nxt   = 1'b0;
            out_data_nxt  = {7'b0, 1'b0, {SLOT_W{1'b0}}, acc,
                             in_tdata[39:28], in_tdata[27:16], score};
            if (acc) begin
              age_nxt = age_r + 1'b1;
              e_nxt   = '{age: age_r, second: in_tdata[39:28],
                          first: in_tdata[27:16], score: score};
              if (count_r < CW'(HEAP_DEPTH)) begin
                count_nxt = count_r + 1'b1;
                pos_nxt   = count_r[AW-1:0];
                state_nxt = ST_UP_RD;
              end else begin
                pos_nxt   = '0;
                repl_nxt  = 1'b1;
                state_nxt = ST_DN_L;
              end
            end
          end else begin
            tally_nxt = tally_inc;
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          rd_addr   = par;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (key_less(e_r, rd_data)) begin
          wr_data   = rd_data;
          pos_nxt   = par;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DN_L: begin
        rd_addr   = AW'(lidx);
        state_nxt = ST_DN_R;
      end
      ST_DN_R: begin
        rd_addr   = AW'(ridx);
        lch_nxt   = rd_data;
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = best;
        // a replacement moves the new minimum into the threshold
        if (pos_r == '0 && repl_r) thr_nxt = best.score;
        if (moved) begin
          pos_nxt   = AW'(best_idx);
          state_nxt = ST_DN_L;
        end else begin
          repl_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP_A: begin
        out_valid_nxt = 1'b1;
        out_pop_nxt   = 1'b1;
        out_data_nxt  = {7'b0, 1'b0, SLOT_W'(count_r - 1'b1), 1'b0,
                         rd_data.second, rd_data.first, rd_data.score};
        count_nxt = count_r - 1'b1;
        rd_addr   = AW'(count_r - 1'b1);
        if (count_r == CW'(1)) state_nxt = ST_IDLE;
        else state_nxt = ST_POP_B;
      end
      ST_POP_B: begin
        e_nxt     = rd_data;
        pos_nxt   = '0;
        repl_nxt  = 1'b0;
        state_nxt = ST_DN_L;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) thr_nxt = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      thr_r       <= '0;
      tally_r     <= '0;
      age_r       <= '0;
      repl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      thr_r       <= thr_nxt;
      tally_r     <= tally_nxt;
      age_r       <= age_nxt;
      repl_r      <= repl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    lch_r      <= lch_nxt;
    pos_r      <= pos_nxt;
    out_pop_r  <= out_pop_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input taken while heap busy");

  a_cfg_thr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (thr_r == $past(cfg_wr_data)))
    else $error("threshold not loaded by config write");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_A) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not shrink heap");
`endif

endmodule

@@ dv/pmtk_checker.sv @@
`timescale 1ns / 1ps
module pmtk_checker
  import pmtk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_DW-1:0]   in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_DW-1:0]  out_tdata,
  input  logic               out_tuser,
  input  logic               cfg_wr_en,
  input  logic [SCORE_W-1:0] cfg_wr_data,
  output int                 fail_count,
  output int                 pending,
  output int                 n_pair,
  output int                 n_pop,
  output int                 n_kept
);

  localparam int DEPTH = HEAP_DEPTH_DEF;

  typedef struct {
    logic               is_pop;
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   first;
    logic [ROW_W-1:0]   second;
    logic               acc;
    logic [SLOT_W-1:0]  slot;
    logic               empty;
  } edge_report_t;

  edge_report_t report_q[$];

  logic [SCORE_W-1:0] h_score[DEPTH];
  logic [ROW_W-1:0]   h_first[DEPTH];
  logic [ROW_W-1:0]   h_second[DEPTH];
  logic [AGE_W-1:0]   h_age[DEPTH];
  int unsigned        fill;
  logic [SCORE_W-1:0] thr;
  logic [SCORE_W-1:0] tally;
  logic [AGE_W-1:0]   stamp;

  function automatic bit ranks_below(int unsigned i, int unsigned j);
    if (h_score[i] != h_score[j]) return h_score[i] < h_score[j];
    return h_age[i] < h_age[j];
  endfunction

  task automatic swap_slots(int unsigned i, int unsigned j);
    logic [SCORE_W-1:0] ts;
    logic [ROW_W-1:0]   tf, tsec;
    logic [AGE_W-1:0]   ta;
    ts = h_score[i]; tf = h_first[i]; tsec = h_second[i]; ta = h_age[i];
    h_score[i] = h_score[j]; h_first[i] = h_first[j];
    h_second[i] = h_second[j]; h_age[i] = h_age[j];
    h_score[j] = ts; h_first[j] = tf; h_second[j] = tsec; h_age[j] = ta;
  endtask

  task automatic bubble_up(int unsigned pos);
    int unsigned par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!ranks_below(pos, par)) break;
      swap_slots(pos, par);
      pos = par;
    end
  endtask

  task automatic bubble_down(int unsigned pos);
    int unsigned l, r, best;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < fill && ranks_below(l, best)) best = l;
      if (r < fill && ranks_below(r, best)) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endtask

  task automatic offer_edge(input logic [SCORE_W-1:0] sc, input logic [ROW_W-1:0] f,
                            input logic [ROW_W-1:0] s, output logic kept);
    int unsigned at;
    kept = 1'b0;
    if (sc < thr) return;
    if (fill < DEPTH) begin
      at = fill;
      fill++;
    end else begin
      if (!(sc > thr)) return;
      at = 0;
    end
    h_score[at] = sc; h_first[at] = f; h_second[at] = s; h_age[at] = stamp;
    if (at == 0 && fill == DEPTH && thr <= sc && fill != 0 && at != fill - 1) begin
      bubble_down(0);
      thr = h_score[0];
    end else begin
      bubble_up(at);
    end
    stamp++;
    kept = 1'b1;
  endtask

  task automatic predict_item(input logic [IN_DW-1:0] d, input logic op, input logic last);
    edge_report_t e;
    logic kept;
    e = '{default: '0};
    if (op == OP_POP) begin
      e.is_pop = 1'b1;
      n_pop++;
      if (fill == 0) begin
        e.empty = 1'b1;
      end else begin
        e.score = h_score[0]; e.first = h_first[0]; e.second = h_second[0];
        e.slot = SLOT_W'(fill - 1);
        fill--;
        if (fill > 0) begin
          h_score[0] = h_score[fill]; h_first[0] = h_first[fill];
          h_second[0] = h_second[fill]; h_age[0] = h_age[fill];
          bubble_down(0);
        end
      end
      report_q.push_back(e);
      return;
    end
    if (d[7:0] == d[15:8] && d[7:0] != 0 && tally < MAX_LEN_DEF) tally++;
    if (!last) return;
    e.score = tally;
    e.first = d[27:16];
    e.second = d[39:28];
    tally = '0;
    offer_edge(e.score, e.first, e.second, kept);
    e.acc = kept;
    n_pair++;
    if (kept) n_kept++;
    report_q.push_back(e);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    n_pair = 0;
    n_pop = 0;
    n_kept = 0;
    fill = 0;
    thr = '0;
    tally = '0;
    stamp = '0;
  end

  always @(posedge clk) begin
    edge_report_t e;
    if (!rst_n) begin
      fill = 0;
      thr = '0;
      tally = '0;
      stamp = '0;
      report_q.delete();
    end else begin
      if (cfg_wr_en) thr = cfg_wr_data;
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = report_q.pop_front();
          check_field("is_pop", e.is_pop, out_tuser);
          check_field("out_score", e.score, out_tdata[12:0]);
          check_field("out_first", e.first, out_tdata[24:13]);
          check_field("out_second", e.second, out_tdata[36:25]);
          check_field("accepted", e.acc, out_tdata[37]);
          check_field("slot", e.slot, out_tdata[47:38]);
          check_field("empty_res", e.empty, out_tdata[48]);
        end
      end
    end
    pending = report_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import pmtk_pkg::*;

  localparam int SETTLE = 120;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_DW-1:0]   in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_DW-1:0]  out_tdata;
  logic               out_tuser;
  logic               cfg_wr_en = 1'b0;
  logic [SCORE_W-1:0] cfg_wr_data = '0;

  int fail_count, pending, n_pair, n_pop, n_kept;
  int tx_pct = 0;
  int rx_pct = 0;
  bit hold_req = 0;
  int quiet = 0;

  always #1 clk = ~clk;

  pair_match_top_k_selector uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  pmtk_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending),
    .n_pair(n_pair), .n_pop(n_pop), .n_kept(n_kept)
  );

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic put(input logic op, input logic [7:0] a, input logic [7:0] b,
                     input logic [11:0] f, input logic [11:0] s, input logic last);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {s, f, b, a};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // each idle cycle taken with probability tx_pct
    while ($urandom_range(0, 99) < tx_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic pop_min();
    put(OP_POP, 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
  endtask

  // a row pair of given length, matching symbols with probability match_pct
  task automatic send_pair(int len, int match_pct);
    logic [7:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = 8'($urandom_range(0, 255));
      b = ($urandom_range(0, 99) < match_pct) ? a : 8'($urandom_range(0, 255));
      put(OP_ELEM, a, b, 12'($urandom), 12'($urandom), i == len - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_floor(logic [SCORE_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic mixed_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) pop_min();
      else if ($urandom_range(0, 99) < 8) put(OP_ELEM, 8'($urandom), 8'($urandom),
                                              12'($urandom), 12'($urandom), 1'($urandom));
      else send_pair($urandom_range(1, 5), 60);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_pct = 6;
    rx_pct = 66;
    // directed: empty pop, score extremes, rows at the limits, threshold edges
    pop_min();
    put(OP_ELEM, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0);
    put(OP_ELEM, 8'd5, 8'd5, 12'd0, 12'd0, 1'b0);
    put(OP_ELEM, 8'd255, 8'd255, 12'd0, 12'd0, 1'b0);
    put(OP_ELEM, 8'd1, 8'd2, 12'd4095, 12'd0, 1'b1);
    put(OP_ELEM, 8'd0, 8'd0, 12'd0, 12'd4095, 1'b1);
    put(OP_ELEM, 8'd7, 8'd7, 12'd4095, 12'd4095, 1'b1);
    put(OP_ELEM, 8'd9, 8'd9, 12'd1, 12'd2, 1'b0);
    pop_min();
    put(OP_ELEM, 8'd9, 8'd9, 12'd3, 12'd4, 1'b1);
    pop_min();
    pop_min();
    pop_min();
    pop_min();
    set_floor(13'd3);
    send_pair(2, 100);
    send_pair(3, 100);
    send_pair(4, 100);
    pop_min();
    pop_min();
    pop_min();

    // phase 1: sender rarely idles, receiver mostly stalls
    set_floor(13'd1);
    mixed_traffic(40);
    hold_req = 1;
    mixed_traffic(30);
    drain();
    mixed_traffic(30);

    // phase 2: top threshold floor, then mixed traffic
    tx_pct = 66;
    rx_pct = 6;
    set_floor(13'd4096);
    send_pair(5, 100);
    pop_min();
    set_floor(13'd2);
    mixed_traffic(60);

    // phase 3: no idling, fill the store and run it full
    tx_pct = 0;
    rx_pct = 0;
    set_floor(13'd0);
    for (int i = 0; i < 1030; i++) send_pair(1, 50);
    for (int i = 0; i < 40; i++) send_pair($urandom_range(1, 4), 70);
    for (int i = 0; i < 60; i++) pop_min();
    mixed_traffic(20);

    drain();
    $display("covered %0d scored pairs (%0d stored) and %0d pops", n_pair, n_kept, n_pop);
    $display("three idling modes, threshold floor 0..4096, full store with replacement");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
